// File: rtl/core/otq_pkg.sv
// Shared types and constants for the ordered timer queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package otq_pkg;

	localparam int TIMERS_DEF = 16;
	localparam int FN_W       = 2;
	localparam int ID_W       = 4;
	localparam int DELAY_W    = 32;
	localparam int TIME_W     = 64;
	localparam int ST_W       = 3;
	localparam int IN_DATA_W  = 104;  // 4 + 32 + 64 = 100, padded to whole bytes
	localparam int OUT_DATA_W = 72;   // 4 + 64 = 68, padded to whole bytes

	// request kinds
	localparam logic [FN_W-1:0] FN_CHECK = 2'd0;
	localparam logic [FN_W-1:0] FN_ADD   = 2'd1;
	localparam logic [FN_W-1:0] FN_DEL   = 2'd2;

	// result status codes
	localparam logic [ST_W-1:0] ST_ADDED   = 3'd0;
	localparam logic [ST_W-1:0] ST_REJECT  = 3'd1;
	localparam logic [ST_W-1:0] ST_DELETED = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTPEND = 3'd3;
	localparam logic [ST_W-1:0] ST_FIRED   = 3'd4;
	localparam logic [ST_W-1:0] ST_NONE    = 3'd5;

	// chain operations broadcast to every cell
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;
	localparam logic [1:0] OP_POP  = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [TIME_W-1:0] key;    // new expiry on add, current time on check
		logic [ID_W-1:0]   timer;  // timer to insert or to look up
	} cmd_t;

	typedef struct packed {
		logic              valid;
		logic              le;     // valid and expiry at or before key
		logic              match;  // valid and holds the looked-up timer
		logic              hit;    // match here or in any cell toward the head
		logic [TIME_W-1:0] expire;
		logic [ID_W-1:0]   timer;
	} link_t;

endpackage

// File: rtl/core/otq_cell.sv
// One slot of the sorted timer chain: expiry, timer id and valid bit.
// Depends on otq_pkg; instantiated in a row by ordered_timer_queue.
`timescale 1ns / 1ps

module otq_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  otq_pkg::cmd_t  cmd,
	input  otq_pkg::link_t prev,
	input  otq_pkg::link_t next,
	output otq_pkg::link_t link
);
	import otq_pkg::*;

	logic              valid_q;
	logic [TIME_W-1:0] expire_q;
	logic [ID_W-1:0]   timer_q;

	logic              valid_d;
	logic [TIME_W-1:0] expire_d;
	logic [ID_W-1:0]   timer_d;

	logic le;
	logic match;

	assign le    = valid_q && (expire_q <= cmd.key);
	assign match = valid_q && (timer_q == cmd.timer);

	assign link.valid  = valid_q;
	assign link.le     = le;
	assign link.match  = match;
	assign link.hit    = prev.hit | match;
	assign link.expire = expire_q;
	assign link.timer  = timer_q;

	always_comb begin
		valid_d  = valid_q;
		expire_d = expire_q;
		timer_d  = timer_q;
		case (cmd.op)
			OP_ADD: begin
				// stay if not later than the new expiry, else insert here or shift right
				if (!le) begin
					if (prev.le) begin
						valid_d  = 1'b1;
						expire_d = cmd.key;
						timer_d  = cmd.timer;
					end else begin
						valid_d  = prev.valid;
						expire_d = prev.expire;
						timer_d  = prev.timer;
					end
				end
			end
			OP_DEL: begin
				// close the gap behind the removed slot
				if (prev.hit | match) begin
					valid_d  = next.valid;
					expire_d = next.expire;
					timer_d  = next.timer;
				end
			end
			OP_POP: begin
				valid_d  = next.valid;
				expire_d = next.expire;
				timer_d  = next.timer;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		expire_q <= expire_d;
		timer_q  <= timer_d;
	end

endmodule

// File: rtl/core/ordered_timer_queue.sv
// Ordered timer queue: a request register feeding a row of cells kept sorted by expiry.
// Requests are registered, then their results are registered on m_axis. One request is
// held at a time; a new one is taken once the last result of the held one is loaded. A
// multi-timer check gives one result per cycle while m_axis_tready stays high.
// Reset (arst_n low, asynchronous): empties the queue and drops any held request or result.
// Depends on otq_pkg and otq_cell.
`timescale 1ns / 1ps

module ordered_timer_queue #(
	parameter int TIMERS = otq_pkg::TIMERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [3:0] timer_id, [35:4] delay, [99:36] now_time, [103:100] zero
	input  logic [otq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] func
	input  logic [otq_pkg::FN_W-1:0]       s_axis_tuser,
	// result channel
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] out_timer, [67:4] expire_time, [71:68] zero
	output logic [otq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [2:0] status
	output logic [otq_pkg::ST_W-1:0]       m_axis_tuser,
	output logic                           m_axis_tlast
);
	import otq_pkg::*;

	// ---------------------------------------------------------------
	// Request register: holds one request until its last result is loaded for output.
	// The expiry of an add is formed here, so the chain sees a
	// registered key: now_time plus delay, saturating at all ones.
	// ---------------------------------------------------------------
	logic              req_valid_q;
	logic [FN_W-1:0]   req_func_q;
	logic [ID_W-1:0]   req_id_q;
	logic [TIME_W-1:0] req_key_q;

	logic [ID_W-1:0]    in_id;
	logic [DELAY_W-1:0] in_delay;
	logic [TIME_W-1:0]  in_now;
	logic [TIME_W:0]    in_sum;
	logic [TIME_W-1:0]  in_key;
	logic               in_take;

	assign in_id    = s_axis_tdata[ID_W-1:0];
	assign in_delay = s_axis_tdata[ID_W+DELAY_W-1:ID_W];
	assign in_now   = s_axis_tdata[ID_W+DELAY_W+TIME_W-1:ID_W+DELAY_W];
	assign in_sum   = {1'b0, in_now} + {{(TIME_W+1-DELAY_W){1'b0}}, in_delay};
	assign in_key   = (s_axis_tuser == FN_ADD)
		? (in_sum[TIME_W] ? {TIME_W{1'b1}} : in_sum[TIME_W-1:0])
		: in_now;

	assign s_axis_tready = !req_valid_q;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// ---------------------------------------------------------------
	// Cell chain. Slot 0 is the head (earliest expiry). The head's left
	// neighbor always reads as "not later" so that an add lands in
	// slot 0 when every queued timer expires later.
	// ---------------------------------------------------------------
	cmd_t  cmd;
	link_t links [TIMERS];
	link_t head_tie;
	link_t tail_tie;

	assign head_tie = '{valid: 1'b0, le: 1'b1, match: 1'b0, hit: 1'b0,
		expire: '0, timer: '0};
	assign tail_tie = '{valid: 1'b0, le: 1'b0, match: 1'b0, hit: 1'b0,
		expire: '0, timer: '0};

	for (genvar i = 0; i < TIMERS; i++) begin : g_cell
		link_t prev_link;
		link_t next_link;
		if (i == 0) begin : g_head
			assign prev_link = head_tie;
		end else begin : g_mid_l
			assign prev_link = links[i-1];
		end
		if (i == TIMERS - 1) begin : g_tail
			assign next_link = tail_tie;
		end else begin : g_mid_r
			assign next_link = links[i+1];
		end
		otq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.prev   (prev_link),
			.next   (next_link),
			.link   (links[i])
		);
	end

	// Timer ids are unique in the chain, so at most one cell matches:
	// an OR over the masked expiries picks out the matching one.
	logic [TIME_W-1:0] match_expire;
	always_comb begin
		match_expire = '0;
		for (int j = 0; j < TIMERS; j++) begin
			match_expire = match_expire | (links[j].match ? links[j].expire : '0);
		end
	end

	logic any_match;
	logic chain_full;
	logic id_ok;
	logic head_due;
	logic next_due;

	assign any_match  = links[TIMERS-1].hit;
	assign chain_full = links[TIMERS-1].valid;
	assign id_ok      = ({{(32-ID_W){1'b0}}, req_id_q} < 32'(TIMERS));
	assign head_due   = links[0].le;
	assign next_due   = links[1].le;  // becomes the head after this pop

	// ---------------------------------------------------------------
	// Result register. A new result is loaded when the slot is empty
	// or being taken in this cycle.
	// ---------------------------------------------------------------
	logic              out_valid_q;
	logic [ST_W-1:0]   out_status_q;
	logic [ID_W-1:0]   out_timer_q;
	logic [TIME_W-1:0] out_expire_q;
	logic              out_last_q;

	logic              out_free;
	logic              act;
	logic              emit;
	logic              done;
	logic [ST_W-1:0]   res_status;
	logic [ID_W-1:0]   res_timer;
	logic [TIME_W-1:0] res_expire;
	logic              res_last;

	assign out_free = !out_valid_q || m_axis_tready;
	assign act      = req_valid_q && out_free;

	always_comb begin
		cmd.op     = OP_NONE;
		cmd.key    = req_key_q;
		cmd.timer  = req_id_q;
		emit       = 1'b0;
		done       = 1'b0;
		res_status = ST_NONE;
		res_timer  = req_id_q;
		res_expire = '0;
		res_last   = 1'b1;
		if (act) begin
			case (req_func_q)
				FN_ADD: begin
					emit = 1'b1;
					done = 1'b1;
					if (!id_ok) begin
						res_status = ST_REJECT;
					end else if (any_match) begin
						// already pending: report the expiry it has
						res_status = ST_REJECT;
						res_expire = match_expire;
					end else if (chain_full) begin
						res_status = ST_REJECT;
					end else begin
						cmd.op     = OP_ADD;
						res_status = ST_ADDED;
						res_expire = req_key_q;
					end
				end
				FN_DEL: begin
					emit = 1'b1;
					done = 1'b1;
					if (any_match) begin
						cmd.op     = OP_DEL;
						res_status = ST_DELETED;
						res_expire = match_expire;
					end else begin
						res_status = ST_NOTPEND;
					end
				end
				FN_CHECK: begin
					emit = 1'b1;
					if (head_due) begin
						// pop the head; hold the request while the next one is due too
						cmd.op     = OP_POP;
						res_status = ST_FIRED;
						res_timer  = links[0].timer;
						res_expire = links[0].expire;
						res_last   = !next_due;
						done       = !next_due;
					end else begin
						res_status = ST_NONE;
						res_timer  = '0;
						done       = 1'b1;
					end
				end
				default: begin
					// unused request kind: drop it silently
					done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				req_valid_q <= 1'b1;
			end else if (done) begin
				req_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_func_q <= s_axis_tuser;
			req_id_q   <= in_id;
			req_key_q  <= in_key;
		end
		if (emit) begin
			out_status_q <= res_status;
			out_timer_q  <= res_timer;
			out_expire_q <= res_expire;
			out_last_q   <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-ID_W-TIME_W){1'b0}}, out_expire_q, out_timer_q};

endmodule

// File: rtl/core/otq_checker.sv
// Port-level checks for ordered_timer_queue, attached with a bind statement.
// Depends on otq_pkg.
`timescale 1ns / 1ps

module otq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [otq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [otq_pkg::ST_W-1:0]       m_axis_tuser,
	input logic                           m_axis_tlast
);
	import otq_pkg::*;

	// a held result does not change until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// one request in flight: no new transaction right after one is taken
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is held");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= ST_NONE))
		else $error("status code out of range");

	// only fired timers may be followed by more results of the same request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_FIRED) |-> m_axis_tlast)
		else $error("single-result request without last");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_NONE) |-> (m_axis_tdata == '0))
		else $error("nothing-expired result carries data");

endmodule

bind ordered_timer_queue otq_checker u_otq_checker (.*);

// File: bench/ordered_timer_queue_tb.sv
// Self-checking bench for ordered_timer_queue: drives add, delete, check and unused requests and
// compares every result with a timer-queue predictor kept inside the bench or a directed-table row.
// Depends on otq_pkg and the ordered_timer_queue RTL.
`timescale 1ns / 1ps

module ordered_timer_queue_tb;

	import otq_pkg::*;

	localparam int NUM_TIMERS     = TIMERS_DEF;
	localparam int RANDOM_ITEMS   = 106;
	localparam int HOLDOFF_CYCLES = 60;
	localparam int TAIL_CYCLES    = 10;
	localparam int CYCLE_LIMIT    = 200_000;
	localparam int NUM_ROWS       = 24;

	// request kind with no meaning: the block must swallow it silently
	localparam logic [FN_W-1:0] FN_UNUSED = 2'd3;

	localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
	localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

	typedef struct {
		logic [ST_W-1:0]   status;
		logic [ID_W-1:0]   timer;
		logic [TIME_W-1:0] expire;
		logic              last;
	} timer_report_t;

	// one request of the directed table; typed rows carry their result (timer is the id)
	typedef struct {
		logic [FN_W-1:0]    fn;
		logic [ID_W-1:0]    id;
		logic [DELAY_W-1:0] dly;
		logic [TIME_W-1:0]  now_v;
		bit                 typed;
		logic [ST_W-1:0]    status;
		logic [TIME_W-1:0]  expire;
	} request_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [FN_W-1:0]       s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [ST_W-1:0]       m_axis_tuser;
	logic                  m_axis_tlast;

	// predictor state: sorted queue of expiries and the timers that own them
	logic [TIME_W-1:0] q_expiry [NUM_TIMERS];
	logic [ID_W-1:0]   q_timer [NUM_TIMERS];
	int                q_count = 0;
	bit                armed [NUM_TIMERS];

	timer_report_t awaited_reports[$];
	request_row_t  directed_rows[NUM_ROWS];

	int mismatches = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit holdoff_request = 1'b0;

	ordered_timer_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ordered_timer_queue: mismatch");
			$finish;
		end
	end

	// Work out the results of one accepted request and advance the queue state.
	function automatic void compute_reports(input logic [FN_W-1:0] fn,
			input logic [ID_W-1:0] id, input logic [DELAY_W-1:0] dly,
			input logic [TIME_W-1:0] now_v, ref timer_report_t reps[$]);
		logic [TIME_W:0]   sum;
		logic [TIME_W-1:0] exp_v;
		timer_report_t     rep;
		int                pos;
		int                at;
		reps.delete();
		at = -1;
		for (int i = 0; i < q_count; i++)
			if (at < 0 && q_timer[i] == id)
				at = i;
		case (fn)
			FN_ADD: begin
				if (armed[id]) begin
					rep = '{ST_REJECT, id, (at >= 0) ? q_expiry[at] : '0, 1'b1};
				end else if (q_count >= NUM_TIMERS) begin
					rep = '{ST_REJECT, id, '0, 1'b1};
				end else begin
					// saturate instead of wrapping past the largest time
					sum = {1'b0, now_v} + {{(TIME_W - DELAY_W + 1){1'b0}}, dly};
					exp_v = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
					// go behind every timer that does not expire later
					pos = 0;
					while (pos < q_count && q_expiry[pos] <= exp_v)
						pos++;
					for (int i = q_count; i > pos; i--) begin
						q_expiry[i] = q_expiry[i-1];
						q_timer[i] = q_timer[i-1];
					end
					q_expiry[pos] = exp_v;
					q_timer[pos] = id;
					q_count++;
					armed[id] = 1'b1;
					rep = '{ST_ADDED, id, exp_v, 1'b1};
				end
				reps.push_back(rep);
			end
			FN_DEL: begin
				if (!armed[id] || at < 0) begin
					armed[id] = 1'b0;
					rep = '{ST_NOTPEND, id, '0, 1'b1};
				end else begin
					rep = '{ST_DELETED, id, q_expiry[at], 1'b1};
					for (int i = at; i + 1 < q_count; i++) begin
						q_expiry[i] = q_expiry[i+1];
						q_timer[i] = q_timer[i+1];
					end
					q_count--;
					armed[id] = 1'b0;
				end
				reps.push_back(rep);
			end
			FN_CHECK: begin
				// pop from the head while the earliest timer has expired
				while (q_count > 0 && reps.size() < NUM_TIMERS && q_expiry[0] <= now_v) begin
					rep = '{ST_FIRED, q_timer[0], q_expiry[0], 1'b0};
					armed[q_timer[0]] = 1'b0;
					for (int i = 0; i + 1 < q_count; i++) begin
						q_expiry[i] = q_expiry[i+1];
						q_timer[i] = q_timer[i+1];
					end
					q_count--;
					reps.push_back(rep);
				end
				if (reps.size() == 0)
					reps.push_back('{ST_NONE, '0, '0, 1'b1});
				else
					reps[reps.size()-1].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Offer one request in the current burst, wait for its transaction, then queue its results.
	task automatic issue_request(input logic [FN_W-1:0] fn, input logic [ID_W-1:0] id,
			input logic [DELAY_W-1:0] dly, input logic [TIME_W-1:0] now_v,
			input bit typed = 1'b0, input logic [ST_W-1:0] typed_status = '0,
			input logic [TIME_W-1:0] typed_expire = '0);
		timer_report_t reps[$];
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
			                                         : $urandom_range(1, 6);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W - TIME_W - DELAY_W - ID_W){1'b0}}, now_v, dly, id};
		s_axis_tuser  <= fn;
		do
			@(posedge clk);
		while (!s_axis_tready);
		compute_reports(fn, id, dly, now_v, reps);
		if (typed)
			awaited_reports.push_back('{typed_status, id, typed_expire, 1'b1});
		else
			foreach (reps[i])
				awaited_reports.push_back(reps[i]);
	endtask

	// Hold the request channel until every awaited result has come back.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: one long hold-off on request, otherwise rotating stall patterns.
	initial begin : result_sink
		logic [15:0] pattern;
		int          seg_left;
		pattern = '1;
		seg_left = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (holdoff_request) begin
				holdoff_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
					                                      : (16'($urandom) | 16'h1);
					seg_left = $urandom_range(8, 40);
				end
				m_axis_tready <= pattern[0];
				pattern = {pattern[0], pattern[15:1]};
				seg_left--;
				@(posedge clk);
			end
		end
	end

	// Compare each result transaction with the oldest awaited one.
	always @(posedge clk) begin : result_check
		timer_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_reports.size() == 0) begin
				$error("unexpected result: status %0d timer %0d expire %h",
				       m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[67:4]);
				mismatches++;
			end else begin
				want = awaited_reports.pop_front();
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[3:0] !== want.timer) begin
					$error("out_timer: expected %0d, got %0d", want.timer, m_axis_tdata[3:0]);
					mismatches++;
				end
				if (m_axis_tdata[67:4] !== want.expire) begin
					$error("expire_time: expected %h, got %h", want.expire, m_axis_tdata[67:4]);
					mismatches++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [TIME_W-1:0]  clock_now;
		logic [TIME_W-1:0]  step;
		logic [DELAY_W-1:0] dly;
		logic [ID_W-1:0]    id;
		logic [FN_W-1:0]    fn;
		int                 items;
		int                 fills;
		int                 pick;
		int                 adds;

		foreach (armed[i])
			armed[i] = 1'b0;

		// fn, id, delay, now, typed, status, expire
		directed_rows = '{
			'{FN_CHECK,  4'd0,  32'd0,    64'd0,    1'b1, ST_NONE,    64'd0},
			'{FN_DEL,    4'd5,  32'd0,    64'd0,    1'b1, ST_NOTPEND, 64'd0},
			'{FN_ADD,    4'd3,  32'd100,  64'd1000, 1'b1, ST_ADDED,   64'd1100},
			'{FN_ADD,    4'd3,  32'd5,    64'd0,    1'b1, ST_REJECT,  64'd1100},
			'{FN_ADD,    4'd15, DELAY_MAX, TIME_MAX, 1'b1, ST_ADDED,  TIME_MAX},
			'{FN_ADD,    4'd0,  32'd0,    64'd0,    1'b1, ST_ADDED,   64'd0},
			// same expiry as timer 3: must fire after it
			'{FN_ADD,    4'd7,  32'd100,  64'd1000, 1'b1, ST_ADDED,   64'd1100},
			'{FN_ADD,    4'd9,  DELAY_MAX, 64'd0,   1'b1, ST_ADDED,   64'h0000_0000_FFFF_FFFF},
			'{FN_UNUSED, 4'd12, 32'd77,   64'd5000, 1'b0, ST_NONE,    64'd0},
			'{FN_DEL,    4'd9,  32'd0,    64'd0,    1'b1, ST_DELETED, 64'h0000_0000_FFFF_FFFF},
			'{FN_CHECK,  4'd0,  32'd0,    64'd1100, 1'b0, ST_NONE,    64'd0},
			'{FN_CHECK,  4'd0,  32'd0,    64'd1099, 1'b1, ST_NONE,    64'd0},
			// sum overflows by exactly one: saturates, ties with timer 15
			'{FN_ADD,    4'd8,  DELAY_MAX, 64'hFFFF_FFFF_0000_0001, 1'b1, ST_ADDED, TIME_MAX},
			'{FN_ADD,    4'd1,  32'd5,    64'd10,   1'b0, ST_NONE,    64'd0},
			'{FN_ADD,    4'd2,  32'd3,    64'd12,   1'b0, ST_NONE,    64'd0},
			'{FN_ADD,    4'd6,  32'h8000_0000, 64'h8000_0000_0000_0000, 1'b0, ST_NONE, 64'd0},
			'{FN_DEL,    4'd1,  32'd0,    64'd0,    1'b0, ST_NONE,    64'd0},
			'{FN_DEL,    4'd15, 32'd0,    64'd0,    1'b1, ST_DELETED, TIME_MAX},
			'{FN_CHECK,  4'd0,  32'd0,    TIME_MAX, 1'b0, ST_NONE,    64'd0},
			'{FN_CHECK,  4'd0,  32'd0,    TIME_MAX, 1'b1, ST_NONE,    64'd0},
			'{FN_DEL,    4'd15, 32'd0,    64'd0,    1'b1, ST_NOTPEND, 64'd0},
			'{FN_ADD,    4'd10, 32'd0,    64'h5555_5555_5555_5555, 1'b1, ST_ADDED,
			  64'h5555_5555_5555_5555},
			'{FN_CHECK,  4'd0,  32'd0,    64'h5555_5555_5555_5554, 1'b1, ST_NONE, 64'd0},
			'{FN_CHECK,  4'd0,  32'd0,    64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ST_NONE, 64'd0}
		};

		// reset held low from time zero, released on a rising edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			issue_request(directed_rows[r].fn, directed_rows[r].id, directed_rows[r].dly,
			              directed_rows[r].now_v, directed_rows[r].typed,
			              directed_rows[r].status, directed_rows[r].expire);

		// pause the sender until the queue of results is empty
		wait_drained();

		// fill the result path while the receiver holds off
		holdoff_request = 1'b1;
		clock_now = {$urandom, $urandom} >> 2;
		items = 0;
		fills = 0;
		while (items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// noise: any kind, any field value
				fn = FN_W'($urandom_range(0, 3));
				issue_request(fn, ID_W'($urandom), $urandom, {$urandom, $urandom});
				if (fn != FN_UNUSED)
					items++;
			end else if (pick < 13 && fills < 2) begin
				// arm every timer, then expire them all in one check
				fills++;
				for (int t = 0; t < NUM_TIMERS; t++) begin
					issue_request(FN_ADD, ID_W'(t), $urandom_range(0, 500), clock_now);
					items++;
				end
				issue_request(FN_CHECK, ID_W'($urandom), $urandom, TIME_MAX);
				items++;
			end else begin
				// typical use: a few adds, maybe a delete, then a check a bit later
				if ($urandom_range(0, 19) == 0)
					clock_now = {$urandom, $urandom};
				adds = $urandom_range(1, 5);
				for (int a = 0; a < adds; a++) begin
					dly = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 200);
					issue_request(FN_ADD, ID_W'($urandom), dly, clock_now);
					items++;
				end
				if ($urandom_range(0, 2) == 0) begin
					id = ID_W'($urandom);
					issue_request(FN_DEL, id, $urandom, {$urandom, $urandom});
					items++;
				end
				step = TIME_W'($urandom_range(0, 250));
				clock_now = (clock_now > TIME_MAX - step) ? TIME_MAX : clock_now + step;
				issue_request(FN_CHECK, ID_W'($urandom), $urandom, clock_now);
				items++;
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_reports.size() == 0)
			$display("ordered_timer_queue: match");
		else
			$display("ordered_timer_queue: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/otq_pkg.sv
rtl/core/otq_cell.sv
rtl/core/ordered_timer_queue.sv
rtl/core/otq_checker.sv
bench/ordered_timer_queue_tb.sv
